// ----- hw/rtl/ecsm_pkg.sv -----
package ecsm_pkg;
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_RED = 2'd3
  } alu_op_t;

  localparam logic [0:0] CFG_CURVE_A     = 1'b0;
  localparam logic [0:0] CFG_FIELD_PRIME = 1'b1;
  localparam int unsigned CFG_IDX_W = 8;
endpackage

// ----- hw/rtl/ecsm_alu.sv -----
module ecsm_alu #(
  parameter int unsigned FIELD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ecsm_pkg::alu_op_t     op,
  input  logic [FIELD_BITS-1:0] opa,
  input  logic [FIELD_BITS-1:0] opb,
  input  logic [FIELD_BITS-1:0] modulus,
  output logic                  done,
  output logic [FIELD_BITS-1:0] res
);
  localparam int unsigned W  = FIELD_BITS;
  localparam int unsigned CW = $clog2(2 * W + 1);

  // Multiply is shift-add with a reduction per bit (MSB first); add, sub and
  // reduce run the same loop over the plain bits of one operand and then add
  // the second term in a final step.
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          mcmode_r, mcmode_nxt;
  logic [W:0]    acc_r, acc_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [W-1:0]  mc_r, mc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W+1:0]  t2, t3;
  logic [W:0]    tr;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mc_nxt   = mc_r;
    cnt_nxt  = cnt_r;
    t2 = '0;
    t3 = '0;
    tr = '0;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      cnt_nxt  = CW'(W + 1);
      case (op)
        ecsm_pkg::OP_MUL: begin sh_nxt = opb; mc_nxt = opa; end
        ecsm_pkg::OP_ADD: begin sh_nxt = opa; mc_nxt = opb; end
        ecsm_pkg::OP_SUB: begin sh_nxt = opa; mc_nxt = modulus - opb; end
        default:          begin sh_nxt = opa; mc_nxt = '0; end
      endcase
    end else if (busy_r) begin
      if (cnt_r == CW'(1)) begin
        // Final step: add the second term of an add or sub and reduce.
        t3 = {1'b0, acc_r};
        if (!mcmode_r) t3 = t3 + {2'b0, mc_r};
        if (t3 >= {2'b0, modulus}) t3 = t3 - {2'b0, modulus};
        if (t3 >= {2'b0, modulus}) t3 = t3 - {2'b0, modulus};
        acc_nxt  = t3[W:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        t2 = {acc_r, 1'b0};
        if (t2 >= {1'b0, modulus, 1'b0}) t2 = t2 - {1'b0, modulus, 1'b0};
        if (t2 >= {2'b0, modulus}) t2 = t2 - {2'b0, modulus};
        if (mcmode_r) begin
          if (sh_r[W-1]) t2 = t2 + {2'b0, mc_r};
        end else begin
          t2 = t2 + {{(W+1){1'b0}}, sh_r[W-1]};
        end
        if (t2 >= {2'b0, modulus}) t2 = t2 - {2'b0, modulus};
        tr = t2[W:0];
        acc_nxt = tr;
        sh_nxt  = {sh_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_comb begin
    mcmode_nxt = mcmode_r;
    if (start) mcmode_nxt = (op == ecsm_pkg::OP_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    mc_r     <= mc_nxt;
    mcmode_r <= mcmode_nxt;
  end

  assign done = done_r;
  assign res  = acc_r[W-1:0];
endmodule

// ----- hw/rtl/ecc_point_scalar_multiply_unit.sv -----
// Channel | Direction | tdata fields (low bit up)            | tuser
// in_     | slave     | point_x, point_y, scalar              | -
// out_    | master    | result_x, result_y                    | at_infinity
// cfg_    | slave     | cfg_index selects, cfg_data is value  | -
// One item takes (k-1) point additions; each runs nine field operations (twelve for
// a doubling) plus an inverse of exactly 2*FIELD_BITS multiplies, and every field
// operation runs in the shared modular unit. Reset is synchronous and active low;
// in_tready is low while an item is at work, and a finished result waits until the
// output is free.
module ecc_point_scalar_multiply_unit #(
  parameter int unsigned FIELD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // point_x, point_y, scalar
  input  logic [2*FIELD_BITS+7:0]       in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // result_x, result_y
  output logic [2*FIELD_BITS-1:0]       out_tdata,
  // at_infinity
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]         cfg_data
);
  localparam int unsigned W = FIELD_BITS;
  localparam int unsigned EW = $clog2(W + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RA    = 5'd1;
  localparam logic [4:0] S_RX    = 5'd2;
  localparam logic [4:0] S_RY    = 5'd3;
  localparam logic [4:0] S_LOOP  = 5'd4;
  localparam logic [4:0] S_D0    = 5'd5;
  localparam logic [4:0] S_D1    = 5'd6;
  localparam logic [4:0] S_D2    = 5'd7;
  localparam logic [4:0] S_D3    = 5'd8;
  localparam logic [4:0] S_A0    = 5'd9;
  localparam logic [4:0] S_A1    = 5'd10;
  localparam logic [4:0] S_INV0  = 5'd11;
  localparam logic [4:0] S_INVSQ = 5'd12;
  localparam logic [4:0] S_INVML = 5'd13;
  localparam logic [4:0] S_M     = 5'd14;
  localparam logic [4:0] S_X0    = 5'd15;
  localparam logic [4:0] S_X1    = 5'd16;
  localparam logic [4:0] S_X2    = 5'd17;
  localparam logic [4:0] S_Y0    = 5'd18;
  localparam logic [4:0] S_Y1    = 5'd19;
  localparam logic [4:0] S_Y2    = 5'd20;
  localparam logic [4:0] S_OUT   = 5'd21;
  localparam logic [4:0] S_D4    = 5'd22;

  logic [W-1:0] ca_r, fp_r;
  logic [4:0]   st_r, st_nxt;
  logic         issued_r, issued_nxt;
  logic [W-1:0] p_r, a_r, bx_r, by_r, qx_r, qy_r, t_r, u_r, e_r, r_r;
  logic [W-1:0] p_nxt, a_nxt, bx_nxt, by_nxt, qx_nxt, qy_nxt, t_nxt, u_nxt, e_nxt, r_nxt;
  logic         qinf_r, qinf_nxt;
  logic [7:0]   k_r, k_nxt;
  logic [EW-1:0] eb_r, eb_nxt;
  logic         ov_r, ov_nxt;
  logic [W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic         oi_r, oi_nxt;
  logic [W-1:0] exp_r;

  ecsm_pkg::alu_op_t op;
  logic [W-1:0] opa, opb, res;
  logic         go, done;

  ecsm_alu #(.FIELD_BITS(W)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(go), .op(op), .opa(opa), .opb(opb),
    .modulus(p_r), .done(done), .res(res)
  );

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
      fp_r <= W'(251);
    end else if (cfg_valid) begin
      if (cfg_index == ecsm_pkg::CFG_IDX_W'(ecsm_pkg::CFG_CURVE_A)) ca_r <= cfg_data;
      else if (cfg_index == ecsm_pkg::CFG_IDX_W'(ecsm_pkg::CFG_FIELD_PRIME))
        fp_r <= cfg_data;
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tuser  = oi_r;

  // Each step state issues one ALU operation, then waits for done and stores.
  always_comb begin
    st_nxt = st_r; issued_nxt = issued_r;
    p_nxt = p_r; a_nxt = a_r; bx_nxt = bx_r; by_nxt = by_r;
    qx_nxt = qx_r; qy_nxt = qy_r; qinf_nxt = qinf_r; t_nxt = t_r; u_nxt = u_r;
    e_nxt = e_r; r_nxt = r_r; k_nxt = k_r; eb_nxt = eb_r;
    ov_nxt = ov_r; ox_nxt = ox_r; oy_nxt = oy_r; oi_nxt = oi_r;
    go = 1'b0; op = ecsm_pkg::OP_RED; opa = '0; opb = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_RA:    begin op = ecsm_pkg::OP_RED; opa = a_r; end
      S_RX:    begin op = ecsm_pkg::OP_RED; opa = bx_r; end
      S_RY:    begin op = ecsm_pkg::OP_RED; opa = by_r; end
      S_D0:    begin op = ecsm_pkg::OP_MUL; opa = qx_r; opb = qx_r; end
      S_D1:    begin op = ecsm_pkg::OP_ADD; opa = t_r; opb = t_r; end
      S_D2:    begin op = ecsm_pkg::OP_ADD; opa = u_r; opb = t_r; end
      S_D3:    begin op = ecsm_pkg::OP_ADD; opa = u_r; opb = a_r; end
      S_D4:    begin op = ecsm_pkg::OP_ADD; opa = by_r; opb = by_r; end
      S_A0:    begin op = ecsm_pkg::OP_SUB; opa = qy_r; opb = by_r; end
      S_A1:    begin op = ecsm_pkg::OP_SUB; opa = qx_r; opb = bx_r; end
      S_INVSQ: begin op = ecsm_pkg::OP_MUL; opa = r_r; opb = r_r; end
      S_INVML: begin op = ecsm_pkg::OP_MUL; opa = r_r; opb = e_r; end
      S_M:     begin op = ecsm_pkg::OP_MUL; opa = u_r; opb = r_r; end
      S_X0:    begin op = ecsm_pkg::OP_MUL; opa = t_r; opb = t_r; end
      S_X1:    begin op = ecsm_pkg::OP_SUB; opa = u_r; opb = bx_r; end
      S_X2:    begin op = ecsm_pkg::OP_SUB; opa = u_r; opb = qx_r; end
      S_Y0:    begin op = ecsm_pkg::OP_SUB; opa = bx_r; opb = u_r; end
      S_Y1:    begin op = ecsm_pkg::OP_MUL; opa = t_r; opb = e_r; end
      S_Y2:    begin op = ecsm_pkg::OP_SUB; opa = e_r; opb = by_r; end
      default: begin op = ecsm_pkg::OP_RED; end
    endcase
    if (st_r inside {S_RA, S_RX, S_RY, S_D0, S_D1, S_D2, S_D3, S_D4, S_A0, S_A1,
                     S_INVSQ, S_INVML, S_M, S_X0, S_X1, S_X2, S_Y0, S_Y1, S_Y2}) begin
      if (!issued_r) begin
        go = 1'b1;
        issued_nxt = 1'b1;
      end
    end
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          p_nxt  = (fp_r < W'(3)) ? W'(3) : fp_r;
          a_nxt  = ca_r;
          bx_nxt = in_tdata[W-1:0];
          by_nxt = in_tdata[2*W-1:W];
          k_nxt  = in_tdata[2*W+7:2*W];
          st_nxt = S_RA;
          issued_nxt = 1'b0;
        end
      end
      S_LOOP: begin
        if (k_r <= 8'd1) st_nxt = S_OUT;
        else if (qinf_r) begin
          qx_nxt = bx_r; qy_nxt = by_r; qinf_nxt = 1'b0; k_nxt = k_r - 8'd1;
        end else if (qx_r == bx_r) begin
          if (qy_r != by_r || by_r == '0) begin
            qinf_nxt = 1'b1; qx_nxt = '0; qy_nxt = '0; k_nxt = k_r - 8'd1;
          end else st_nxt = S_D0;
        end else st_nxt = S_A0;
      end
      S_INV0: begin
        // r = 1, then walk the exponent p - 2 MSB first
        r_nxt = W'(1); eb_nxt = EW'(W);
        st_nxt = S_INVSQ;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ox_nxt = qx_r; oy_nxt = qy_r; oi_nxt = qinf_r;
          st_nxt = S_IDLE;
        end
      end
      default: ;
    endcase
    if (done) begin
      issued_nxt = 1'b0;
      case (st_r)
        S_RA: begin a_nxt = res; st_nxt = S_RX; end
        S_RX: begin bx_nxt = res; st_nxt = S_RY; end
        S_RY: begin
          by_nxt = res; qx_nxt = bx_r; qy_nxt = res; qinf_nxt = 1'b0; st_nxt = S_LOOP;
        end
        S_D0: begin t_nxt = res; st_nxt = S_D1; end
        S_D1: begin u_nxt = res; st_nxt = S_D2; end
        S_D2: begin u_nxt = res; st_nxt = S_D3; end
        S_D3: begin u_nxt = res; st_nxt = S_D4; end
        S_D4: begin t_nxt = res; st_nxt = S_INV0; end
        S_A0: begin u_nxt = res; st_nxt = S_A1; end
        S_A1: begin t_nxt = res; st_nxt = S_INV0; end
        S_INVSQ: begin r_nxt = res; st_nxt = S_INVML; end
        S_INVML: begin
          // The product with the base is kept only where the exponent bit is set.
          if (exp_r[W-1]) r_nxt = res;
          eb_nxt = eb_r - EW'(1);
          st_nxt = (eb_r == EW'(1)) ? S_M : S_INVSQ;
        end
        S_M:  begin t_nxt = res; st_nxt = S_X0; end
        S_X0: begin u_nxt = res; st_nxt = S_X1; end
        S_X1: begin u_nxt = res; st_nxt = S_X2; end
        S_X2: begin u_nxt = res; st_nxt = S_Y0; end
        S_Y0: begin e_nxt = res; qx_nxt = u_r; st_nxt = S_Y1; end
        S_Y1: begin e_nxt = res; st_nxt = S_Y2; end
        S_Y2: begin qy_nxt = res; k_nxt = k_r - 8'd1; st_nxt = S_LOOP; end
        default: ;
      endcase
    end
  end

  // The exponent p - 2 shifts left once per square-and-multiply round.
  always_ff @(posedge clk) begin
    if (st_r == S_INV0) begin
      exp_r <= p_r - W'(2);
    end else if (st_r == S_INVML && done) begin
      exp_r <= {exp_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; issued_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; issued_r <= issued_nxt; ov_r <= ov_nxt;
    end
    p_r <= p_nxt; a_r <= a_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt; qinf_r <= qinf_nxt; t_r <= t_nxt;
    if (st_r == S_INVML && done) u_r <= u_r; else u_r <= u_nxt;
    k_r <= k_nxt; eb_r <= eb_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; oi_r <= oi_nxt;
    r_r <= r_nxt;
    // During inversion e holds the base; the exponent bits come from exp_r.
    if (st_r == S_INV0) e_r <= t_r;
    else if (st_r == S_INVML || st_r == S_INVSQ) e_r <= e_r;
    else e_r <= e_nxt;
  end
endmodule
